// ----- rtl/fm_vas_pkg.sv -----
// ----------------------------------------------------------------------------
// fm_vas_pkg
// Shared types and constants for the FM sound-effect voice allocator and
// sequencer: command codes, chip register constants and the result record.
// ----------------------------------------------------------------------------
package fm_vas_pkg;

    // default number of managed voices
    localparam int DEFAULT_VOICE_COUNT = 8;

    // command codes
    localparam logic [2:0] KIND_PLAY_FIXED = 3'd0;
    localparam logic [2:0] KIND_PLAY_ANY   = 3'd1;
    localparam logic [2:0] KIND_STOP       = 3'd2;
    localparam logic [2:0] KIND_TICK       = 3'd3;
    localparam logic [2:0] KIND_BIND       = 3'd4;
    localparam logic [2:0] KIND_RECORD     = 3'd5;

    // configuration register indexes
    localparam logic CFG_ALLOWED  = 1'b0;
    localparam logic CFG_RESERVED = 1'b1;

    // register reset values
    localparam logic [7:0] ALLOWED_RESET  = 8'hff;
    localparam logic [7:0] RESERVED_RESET = 8'h00;

    // chip register constants
    localparam logic [7:0]  KEYOFF_REG  = 8'h08;
    localparam logic [7:0]  LOW_MASK    = 8'hf8;
    localparam logic [7:0]  OPREG_BASE  = 8'h20;
    localparam logic [7:0]  END_DELAY   = 8'hff;
    localparam logic [23:0] CURSOR_STEP = 24'd3;

    // one result item
    typedef struct packed {
        logic        status;
        logic [2:0]  voice;
        logic        write_valid;
        logic [7:0]  write_addr;
        logic [7:0]  write_data;
        logic        load_patch;
        logic        due;
        logic [23:0] fetch_addr;
        logic        last;
    } res_t;

endpackage

// ----- rtl/fm_voice_allocator_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// fm_voice_allocator_sequencer_top
// Voice allocator and record sequencer for FM sound effects.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_ channel (valid/ready) and give zero to eight
//   result items on the m_ channel (valid/ready); m_last marks the final
//   result of a command. A tick that finds no due voice gives no result.
//   allowed_voices (index 0) and reserved_voices (index 1) are written on
//   the cfg_ channel, which is always ready; write them only while idle.
// Sequencing (one command at a time, s_ready low while it runs):
//   Stop, bind, record and rejections give their single result from the
//   execute state. Fixed play goes on from the execute to the start state.
//   Automatic play searches the voices in order up to the first free one,
//   then gives a key-off for a stolen voice and starts the selected voice.
//   Tick visits each voice in order and gives its results on the way.
//   All of this runs through one per-voice read/write port and one compare
//   and decrement path, indexed by the voice counter.
// Reset and stalls:
//   aresetn clears all voices, priorities, delays and bound patches, and
//   restores the configuration registers. A held result stalls the
//   sequencer in any step that gives a result while m_ready stays low.
// ----------------------------------------------------------------------------
module fm_voice_allocator_sequencer_top
    import fm_vas_pkg::*;
#(
    parameter int VOICE_COUNT = DEFAULT_VOICE_COUNT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // commands
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [2:0]  s_voice_sel,
    input  logic        s_has_patch,
    input  logic [23:0] s_patch_ident,
    input  logic        s_has_sequence,
    input  logic [23:0] s_seq_start,
    input  logic [7:0]  s_prio,
    input  logic [7:0]  s_rec_reg,
    input  logic [7:0]  s_rec_value,
    input  logic [7:0]  s_rec_delay,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [2:0]  m_voice_out,
    output logic        m_write_valid,
    output logic [7:0]  m_write_addr,
    output logic [7:0]  m_write_data,
    output logic        m_load_patch,
    output logic        m_due,
    output logic [23:0] m_fetch_addr,
    output logic        m_last
);

    localparam int VIW = $clog2(VOICE_COUNT);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_KOFF  = 3'd3;
    localparam logic [2:0] ST_START = 3'd4;
    localparam logic [2:0] ST_TICK  = 3'd5;

    // control state
    logic [2:0]             state_reg, state_next;
    logic [7:0]             allowed_reg, allowed_next;
    logic [7:0]             reserved_reg, reserved_next;
    logic [VOICE_COUNT-1:0] active_reg, active_next;
    logic [2:0]             vidx_reg, vidx_next;
    logic [2:0]             best_reg, best_next;
    logic [7:0]             bestp_reg, bestp_next;
    logic                   bestv_reg, bestv_next;
    logic                   m_valid_reg, m_valid_next;
    res_t                   res_reg, res_next;

    // latched command
    logic [2:0]  kind_reg;
    logic        hp_reg;
    logic [23:0] patch_in_reg;
    logic        hs_reg;
    logic [23:0] seq_reg;
    logic [7:0]  prio_in_reg;
    logic [7:0]  rreg_reg;
    logic [7:0]  rval_reg;
    logic [7:0]  rdly_reg;

    // per-voice state
    logic [7:0]  prio_reg   [VOICE_COUNT];
    logic [7:0]  delay_reg  [VOICE_COUNT];
    logic [23:0] patch_reg  [VOICE_COUNT];
    logic [23:0] cursor_reg [VOICE_COUNT];

    // single per-voice write port
    logic        prio_we, delay_we, patch_we, cursor_we;
    logic [7:0]  prio_next, delay_next;
    logic [23:0] patch_next, cursor_next;

    // shared datapath signals
    logic [VIW-1:0]         vsel;
    logic                   voice_ok, voice_allowed, act;
    logic [7:0]             prio_rd, delay_rd, dnew;
    logic [23:0]            patch_rd, cursor_rd, cursor_inc;
    logic                   dyn_bit, cand, last_idx, out_free, emit, accept;
    logic [VOICE_COUNT-1:0] due_vec;
    logic                   more_due;
    logic [7:0]             rec_addr, rec_data;
    res_t                   res_w;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // shared voice read port
    assign vsel      = vidx_reg[VIW-1:0];
    assign voice_ok  = ({1'b0, vidx_reg} < 4'(VOICE_COUNT));
    assign voice_allowed = voice_ok && allowed_reg[vidx_reg];
    assign act       = voice_ok && active_reg[vsel];
    assign prio_rd   = prio_reg[vsel];
    assign delay_rd  = delay_reg[vsel];
    assign patch_rd  = patch_reg[vsel];
    assign cursor_rd = cursor_reg[vsel];
    assign cursor_inc = cursor_rd + CURSOR_STEP;
    assign dnew      = (delay_rd == 8'd0) ? 8'd0 : delay_rd - 8'd1;
    assign last_idx  = (vidx_reg == 3'(VOICE_COUNT - 1));

    // allocation compare
    assign dyn_bit = allowed_reg[vidx_reg] && !reserved_reg[vidx_reg];
    assign cand    = dyn_bit && act && (prio_rd < prio_in_reg)
                     && (!bestv_reg || (prio_rd < bestp_reg));

    // voices still to become due later in this tick
    always_comb begin
        more_due = 1'b0;
        for (int u = 0; u < VOICE_COUNT; u++) begin
            due_vec[u] = active_reg[u] && (delay_reg[u] <= 8'd1);
            if (due_vec[u] && (3'(u) > vidx_reg)) begin
                more_due = 1'b1;
            end
        end
    end

    // record address and data remap
    always_comb begin
        rec_addr = rreg_reg;
        rec_data = rval_reg;
        if (rreg_reg == KEYOFF_REG) begin
            rec_data = (rval_reg & LOW_MASK) | {5'd0, vidx_reg};
        end else if (rreg_reg >= OPREG_BASE) begin
            rec_addr = (rreg_reg & LOW_MASK) | {5'd0, vidx_reg};
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        allowed_next  = allowed_reg;
        reserved_next = reserved_reg;
        active_next   = active_reg;
        vidx_next     = vidx_reg;
        best_next     = best_reg;
        bestp_next    = bestp_reg;
        bestv_next    = bestv_reg;
        prio_we       = 1'b0;
        delay_we      = 1'b0;
        patch_we      = 1'b0;
        cursor_we     = 1'b0;
        prio_next     = 8'd0;
        delay_next    = 8'd0;
        patch_next    = patch_in_reg;
        cursor_next   = seq_reg;
        emit          = 1'b0;
        res_w         = '0;
        res_w.status  = 1'b1;
        res_w.last    = 1'b1;

        // configuration writes
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_ALLOWED) begin
                allowed_next = cfg_data;
            end else begin
                reserved_next = cfg_data & allowed_reg;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    bestv_next = 1'b0;
                    best_next  = 3'd0;
                    bestp_next = 8'd0;
                    if (s_kind == KIND_TICK) begin
                        vidx_next  = 3'd0;
                        state_next = ST_TICK;
                    end else if (s_kind == KIND_PLAY_ANY && s_has_sequence) begin
                        vidx_next  = 3'd0;
                        state_next = ST_SCAN;
                    end else begin
                        vidx_next  = s_voice_sel;
                        state_next = ST_EXEC;
                    end
                end
            end

            // single-result commands and rejections; a fixed play that is taken moves on to start
            ST_EXEC: begin
                if (kind_reg == KIND_PLAY_FIXED && hs_reg && voice_allowed) begin
                    state_next = ST_START;
                end else if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    case (kind_reg)
                        KIND_STOP: begin
                            if (voice_ok) begin
                                active_next[vsel] = 1'b0;
                                prio_we           = 1'b1;
                                delay_we          = 1'b1;
                                res_w.status      = 1'b0;
                                res_w.voice       = vidx_reg;
                                res_w.write_valid = 1'b1;
                                res_w.write_addr  = KEYOFF_REG;
                                res_w.write_data  = {5'd0, vidx_reg};
                            end
                        end
                        KIND_BIND: begin
                            if (voice_allowed && hp_reg) begin
                                res_w.status = 1'b0;
                                res_w.voice  = vidx_reg;
                                if (patch_rd != patch_in_reg) begin
                                    patch_we         = 1'b1;
                                    res_w.load_patch = 1'b1;
                                end
                            end
                        end
                        KIND_RECORD: begin
                            if (act && delay_rd == 8'd0) begin
                                cursor_we         = 1'b1;
                                cursor_next       = cursor_inc;
                                res_w.status      = 1'b0;
                                res_w.voice       = vidx_reg;
                                res_w.write_valid = 1'b1;
                                res_w.write_addr  = rec_addr;
                                res_w.write_data  = rec_data;
                                if (rdly_reg == END_DELAY) begin
                                    active_next[vsel] = 1'b0;
                                end else if (rdly_reg != 8'd0) begin
                                    delay_we   = 1'b1;
                                    delay_next = rdly_reg;
                                end else begin
                                    res_w.due        = 1'b1;
                                    res_w.fetch_addr = cursor_inc;
                                end
                            end
                        end
                        default: begin
                            // rejection result, already set up
                        end
                    endcase
                end
            end

            // search for a free voice, else the weakest busy one of lower priority, else reject
            ST_SCAN: begin
                if (dyn_bit && !act) begin
                    state_next = ST_START;
                end else begin
                    if (cand) begin
                        best_next  = vidx_reg;
                        bestp_next = prio_rd;
                        bestv_next = 1'b1;
                    end
                    if (last_idx) begin
                        if (cand) begin
                            state_next = ST_KOFF;
                        end else if (bestv_reg) begin
                            vidx_next  = best_reg;
                            state_next = ST_KOFF;
                        end else begin
                            state_next = ST_EXEC;
                        end
                    end else begin
                        vidx_next = vidx_reg + 3'd1;
                    end
                end
            end

            // key-off of a stolen voice
            ST_KOFF: begin
                if (out_free) begin
                    emit              = 1'b1;
                    active_next[vsel] = 1'b0;
                    prio_we           = 1'b1;
                    delay_we          = 1'b1;
                    res_w.status      = 1'b0;
                    res_w.voice       = vidx_reg;
                    res_w.write_valid = 1'b1;
                    res_w.write_addr  = KEYOFF_REG;
                    res_w.write_data  = {5'd0, vidx_reg};
                    res_w.last        = 1'b0;
                    state_next        = ST_START;
                end
            end

            // start the selected voice
            ST_START: begin
                if (out_free) begin
                    emit              = 1'b1;
                    active_next[vsel] = 1'b1;
                    prio_we           = 1'b1;
                    prio_next         = prio_in_reg;
                    delay_we          = 1'b1;
                    delay_next        = 8'd1;
                    cursor_we         = 1'b1;
                    res_w.status      = 1'b0;
                    res_w.voice       = vidx_reg;
                    if (hp_reg && patch_rd != patch_in_reg) begin
                        patch_we         = 1'b1;
                        res_w.load_patch = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            // count delays down, report due voices in order
            ST_TICK: begin
                if (!(act && dnew == 8'd0) || out_free) begin
                    if (act) begin
                        delay_we   = 1'b1;
                        delay_next = dnew;
                        if (dnew == 8'd0) begin
                            emit             = 1'b1;
                            res_w.status     = 1'b0;
                            res_w.voice      = vidx_reg;
                            res_w.due        = 1'b1;
                            res_w.fetch_addr = cursor_rd;
                            res_w.last       = !more_due;
                        end
                    end
                    if (last_idx) begin
                        state_next = ST_IDLE;
                    end else begin
                        vidx_next = vidx_reg + 3'd1;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            res_next     = res_w;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            allowed_reg  <= ALLOWED_RESET;
            reserved_reg <= RESERVED_RESET;
            active_reg   <= '0;
            vidx_reg     <= 3'd0;
            best_reg     <= 3'd0;
            bestp_reg    <= 8'd0;
            bestv_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            allowed_reg  <= allowed_next;
            reserved_reg <= reserved_next;
            active_reg   <= active_next;
            vidx_reg     <= vidx_next;
            best_reg     <= best_next;
            bestp_reg    <= bestp_next;
            bestv_reg    <= bestv_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // per-voice priority, delay and bound patch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VOICE_COUNT; i++) begin
                prio_reg[i]  <= 8'd0;
                delay_reg[i] <= 8'd0;
                patch_reg[i] <= 24'd0;
            end
        end else begin
            if (prio_we) begin
                prio_reg[vsel] <= prio_next;
            end
            if (delay_we) begin
                delay_reg[vsel] <= delay_next;
            end
            if (patch_we) begin
                patch_reg[vsel] <= patch_next;
            end
        end
    end

    // sequence cursors and payload, no reset needed
    always_ff @(posedge aclk) begin
        if (cursor_we) begin
            cursor_reg[vsel] <= cursor_next;
        end
        res_reg <= res_next;
        if (accept) begin
            kind_reg     <= s_kind;
            hp_reg       <= s_has_patch;
            patch_in_reg <= s_patch_ident;
            hs_reg       <= s_has_sequence;
            seq_reg      <= s_seq_start;
            prio_in_reg  <= s_prio;
            rreg_reg     <= s_rec_reg;
            rval_reg     <= s_rec_value;
            rdly_reg     <= s_rec_delay;
        end
    end

    // result ports
    assign m_valid       = m_valid_reg;
    assign m_status      = res_reg.status;
    assign m_voice_out   = res_reg.voice;
    assign m_write_valid = res_reg.write_valid;
    assign m_write_addr  = res_reg.write_addr;
    assign m_write_data  = res_reg.write_data;
    assign m_load_patch  = res_reg.load_patch;
    assign m_due         = res_reg.due;
    assign m_fetch_addr  = res_reg.fetch_addr;
    assign m_last        = res_reg.last;

endmodule
